// File: rtl/fdtd_1d_periodic_step_core_assert.svh
// Assertion macros for the periodic 1-D FDTD step core.
// Included by the top level; relies on nothing else.
`ifndef FDTD_1D_PERIODIC_STEP_CORE_ASSERT_SVH
`define FDTD_1D_PERIODIC_STEP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDTD1D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDTD1D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fdtd1d_pkg.sv
// Shared types and constants for the periodic 1-D FDTD step core.
// No dependencies; imported by the update unit and the top level.
`timescale 1ns / 1ps

package fdtd1d_pkg;

  localparam int unsigned FIELD_W    = 32;  // Q8.24 field word
  localparam int unsigned COEF_W     = 17;  // unsigned Q1.16 coefficient
  localparam int unsigned CELL_CNT_W = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned MAX_CELLS_DEF = 1024;

  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned PROD_W     = FIELD_W + COEF_W;
  localparam int unsigned RND_W      = PROD_W + 1;
  localparam int unsigned LO_W       = RND_W - FRAC_SHIFT;

  localparam logic [CELL_CNT_W-1:0] CELL_COUNT_RST = CELL_CNT_W'(1024);
  localparam logic [COEF_W-1:0]     COEF_RST       = COEF_W'(32768);
  localparam logic [RND_W-1:0]      ROUND_HALF     = RND_W'(32768);
  localparam logic [FIELD_W-1:0]    FIELD_SIGN     = {1'b1, {(FIELD_W-1){1'b0}}};

  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COURANT    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Status of the update unit seen by the sequencer.
  typedef struct packed {
    logic valid;  // result word present this cycle
    logic sat;    // result was clamped
    logic busy;   // any stage holds work
  } upd_rsp_t;

endpackage

// File: rtl/fdtd1d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the E and H field stores.
`timescale 1ns / 1ps

module fdtd1d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fdtd1d_upd.sv
// Shared field update unit: new = old + round(coeff * (a - b) / 2^16), saturated.
// Three registered stages (difference, multiply, round/add/clamp); uses fdtd1d_pkg.
`timescale 1ns / 1ps

module fdtd1d_upd #(
  parameter int unsigned AW = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [fdtd1d_pkg::COEF_W-1:0]     coeff_i,
  input  logic [fdtd1d_pkg::FIELD_W-1:0]    old_i,
  input  logic [fdtd1d_pkg::FIELD_W-1:0]    a_i,
  input  logic [fdtd1d_pkg::FIELD_W-1:0]    b_i,
  input  logic [AW-1:0]                     tag_i,
  output fdtd1d_pkg::upd_rsp_t              rsp_o,
  output logic [fdtd1d_pkg::FIELD_W-1:0]    res_o,
  output logic [AW-1:0]                     tag_o
);

  import fdtd1d_pkg::*;

  // stage 1: exact difference as sign and magnitude, biased old value
  logic [FIELD_W-1:0] ab, bb;
  logic               neg_d;
  logic [FIELD_W-1:0] mag_d;

  logic               s1_v_q, s1_neg_q;
  logic [FIELD_W-1:0] s1_mag_q, s1_ob_q;
  logic [AW-1:0]      s1_tag_q;

  logic               s2_v_q, s2_neg_q;
  logic [PROD_W-1:0]  s2_prod_q;
  logic [FIELD_W-1:0] s2_ob_q;
  logic [AW-1:0]      s2_tag_q;

  logic               out_v_q, out_sat_q;
  logic [FIELD_W-1:0] out_res_q;
  logic [AW-1:0]      out_tag_q;

  // stage 3 signals
  logic [RND_W-1:0]   rnd;
  logic [LO_W-1:0]    lo;
  logic [FIELD_W-1:0] lo_f;
  logic [FIELD_W:0]   sum;
  logic [FIELD_W-1:0] nb;
  logic               sat;

  assign ab    = a_i ^ FIELD_SIGN;
  assign bb    = b_i ^ FIELD_SIGN;
  assign neg_d = ab < bb;
  assign mag_d = neg_d ? (bb - ab) : (ab - bb);

  always_comb begin
    rnd  = {1'b0, s2_prod_q} + ROUND_HALF;
    lo   = rnd[RND_W-1:FRAC_SHIFT];
    lo_f = lo[FIELD_W-1:0];
    sum  = {1'b0, s2_ob_q} + {1'b0, lo_f};
    nb   = '0;
    sat  = 1'b0;
    if (|lo[LO_W-1:FIELD_W]) begin
      // step alone exceeds the range: clamp toward its sign
      sat = 1'b1;
      nb  = s2_neg_q ? '0 : '1;
    end else if (!s2_neg_q) begin
      if (sum[FIELD_W]) begin
        sat = 1'b1;
        nb  = '1;
      end else begin
        nb = sum[FIELD_W-1:0];
      end
    end else begin
      if (lo_f > s2_ob_q) begin
        sat = 1'b1;
        nb  = '0;
      end else begin
        nb = s2_ob_q - lo_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= valid_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_neg_q  <= neg_d;
    s1_mag_q  <= mag_d;
    s1_ob_q   <= old_i ^ FIELD_SIGN;
    s1_tag_q  <= tag_i;
    s2_neg_q  <= s1_neg_q;
    s2_prod_q <= PROD_W'(s1_mag_q) * PROD_W'(coeff_i);
    s2_ob_q   <= s1_ob_q;
    s2_tag_q  <= s1_tag_q;
    out_sat_q <= sat;
    out_res_q <= nb ^ FIELD_SIGN;
    out_tag_q <= s2_tag_q;
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.sat   = out_sat_q;
  assign rsp_o.busy  = s1_v_q | s2_v_q | out_v_q;
  assign res_o       = out_res_q;
  assign tag_o       = out_tag_q;

endmodule

// File: rtl/fdtd_1d_periodic_step_core.sv
// Load passes through ST_LOAD, and read through ST_READ and ST_READ_OUT, before the done_o strobe.
// In a step item (n = active cells) each time step walks the RAM read port once
// per cell for E, then once for H, with the shared 3-stage update unit drained
// between passes.
// One item at a time; busy stays high until the result beat, which cannot stall.
// Reset clears control state and the overflow flag; field RAM is not cleared.
`timescale 1ns / 1ps
`include "fdtd_1d_periodic_step_core_assert.svh"

module fdtd_1d_periodic_step_core #(
  parameter int unsigned MAX_CELLS = fdtd1d_pkg::MAX_CELLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fdtd1d_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [fdtd1d_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fdtd1d_pkg::OP_W-1:0]          operation_i,
  input  logic [fdtd1d_pkg::IDX_W-1:0]         cell_index_i,
  input  logic signed [fdtd1d_pkg::FIELD_W-1:0] e_value_i,
  input  logic signed [fdtd1d_pkg::FIELD_W-1:0] h_value_i,
  input  logic [fdtd1d_pkg::STEP_W-1:0]        step_count_i,
  output logic                                 done_o,
  output logic [fdtd1d_pkg::IDX_W-1:0]         cell_index_out_o,
  output logic signed [fdtd1d_pkg::FIELD_W-1:0] e_out_o,
  output logic signed [fdtd1d_pkg::FIELD_W-1:0] h_out_o,
  output logic                                 overflow_o
);

  import fdtd1d_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CELLS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_OUT,
    ST_E_PRE,
    ST_E_RUN,
    ST_E_DRAIN,
    ST_H_PRE,
    ST_H_RUN,
    ST_H_DRAIN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_PRE,
    RK_CELL
  } rd_kind_e;

  // configuration
  logic [CELL_CNT_W-1:0] cell_count_q;
  logic [COEF_W-1:0]     coeff_q;

  // sequencer state
  state_e              state_q, state_d;
  rd_kind_e            rd_kind_q, rd_kind_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic [AW-1:0]       k_q, k_d;
  logic [AW-1:0]       last_q, last_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic                pass_h_q, pass_h_d;
  logic [FIELD_W-1:0]  carry_q, carry_d;
  logic                ovf_q, ovf_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                idx_ok_q, idx_ok_d;
  logic [FIELD_W-1:0]  e_val_q, e_val_d;
  logic [FIELD_W-1:0]  h_val_q, h_val_d;

  // result registers
  logic                done_q, done_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [FIELD_W-1:0]  e_out_q, e_out_d;
  logic [FIELD_W-1:0]  h_out_q, h_out_d;
  logic                ovf_out_q, ovf_out_d;

  // accept-time decode
  logic                idx_ok_in;
  logic [31:0]         cc_ext, n_lim;
  logic [AW-1:0]       last_in;
  logic                run_ok;

  // RAM ports
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [FIELD_W-1:0]  e_rdata, h_rdata;
  logic                e_we, h_we;
  logic [AW-1:0]       wr_addr;
  logic [FIELD_W-1:0]  e_wdata, h_wdata;

  // update unit
  logic                upd_valid;
  logic [FIELD_W-1:0]  upd_old, upd_a, upd_b, upd_res;
  logic [AW-1:0]       upd_tag;
  upd_rsp_t            upd_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CELL_COUNT_RST;
      coeff_q      <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CELL_COUNT: cell_count_q <= cfg_wdata_i[CELL_CNT_W-1:0];
        CFG_COURANT:    coeff_q      <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ok_in = 32'(cell_index_i) < MAX_CELLS;
  assign cc_ext    = 32'(cell_count_q);
  assign n_lim     = (cc_ext > MAX_CELLS) ? 32'(MAX_CELLS) : cc_ext;
  assign last_in   = AW'(n_lim - 32'd1);
  assign run_ok    = (n_lim != 32'd0) && (step_count_i != '0);

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    rd_kind_d = RK_NONE;
    rd_addr_d = rd_addr_q;
    k_d       = k_q;
    last_d    = last_q;
    steps_d   = steps_q;
    pass_h_d  = pass_h_q;
    idx_d     = idx_q;
    idx_ok_d  = idx_ok_q;
    e_val_d   = e_val_q;
    h_val_d   = h_val_q;
    done_d    = 1'b0;
    out_idx_d = out_idx_q;
    e_out_d   = e_out_q;
    h_out_d   = h_out_q;
    ovf_out_d = ovf_out_q;
    rd_en     = 1'b0;
    rd_addr   = k_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d    = cell_index_i;
          idx_ok_d = idx_ok_in;
          e_val_d  = e_value_i;
          h_val_d  = h_value_i;
          case (op_e'(operation_i))
            OP_LOAD: state_d = ST_LOAD;
            OP_READ: state_d = ST_READ;
            OP_STEP: begin
              last_d  = last_in;
              steps_d = step_count_i;
              state_d = run_ok ? ST_E_PRE : ST_FINISH;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_LOAD: begin
        done_d    = 1'b1;
        out_idx_d = idx_q;
        e_out_d   = idx_ok_q ? e_val_q : '0;
        h_out_d   = idx_ok_q ? h_val_q : '0;
        ovf_out_d = ovf_q;
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q);
        state_d = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        done_d    = 1'b1;
        out_idx_d = idx_q;
        e_out_d   = idx_ok_q ? e_rdata : '0;
        h_out_d   = idx_ok_q ? h_rdata : '0;
        ovf_out_d = ovf_q;
        state_d   = ST_IDLE;
      end
      ST_E_PRE: begin
        // fetch the wrap neighbor H[n-1] ahead of cell 0
        rd_en     = 1'b1;
        rd_addr   = last_q;
        rd_kind_d = RK_PRE;
        pass_h_d  = 1'b0;
        k_d       = '0;
        state_d   = ST_E_RUN;
      end
      ST_E_RUN: begin
        rd_en     = 1'b1;
        rd_kind_d = RK_CELL;
        rd_addr_d = k_q;
        if (k_q == last_q) begin
          state_d = ST_E_DRAIN;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_E_DRAIN: begin
        if (rd_kind_q == RK_NONE && !upd_rsp.busy) begin
          state_d = ST_H_PRE;
        end
      end
      ST_H_PRE: begin
        // fetch the wrap neighbor E[0]; H walks down from the top cell
        rd_en     = 1'b1;
        rd_addr   = '0;
        rd_kind_d = RK_PRE;
        pass_h_d  = 1'b1;
        k_d       = last_q;
        state_d   = ST_H_RUN;
      end
      ST_H_RUN: begin
        rd_en     = 1'b1;
        rd_kind_d = RK_CELL;
        rd_addr_d = k_q;
        if (k_q == '0) begin
          state_d = ST_H_DRAIN;
        end else begin
          k_d = k_q - AW'(1);
        end
      end
      ST_H_DRAIN: begin
        if (rd_kind_q == RK_NONE && !upd_rsp.busy) begin
          if (steps_q == STEP_W'(1)) begin
            state_d = ST_FINISH;
          end else begin
            steps_d = steps_q - STEP_W'(1);
            state_d = ST_E_PRE;
          end
        end
      end
      ST_FINISH: begin
        done_d    = 1'b1;
        out_idx_d = '0;
        e_out_d   = '0;
        h_out_d   = '0;
        ovf_out_d = ovf_q;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // feed the update unit from the registered read data of each cell read
  always_comb begin
    upd_valid = (rd_kind_q == RK_CELL);
    upd_tag   = rd_addr_q;
    if (pass_h_q) begin
      upd_old = h_rdata;
      upd_a   = e_rdata;
      upd_b   = carry_q;
    end else begin
      upd_old = e_rdata;
      upd_a   = carry_q;
      upd_b   = h_rdata;
    end
    carry_d = carry_q;
    if (rd_kind_q != RK_NONE) begin
      carry_d = pass_h_q ? e_rdata : h_rdata;
    end
    ovf_d = ovf_q | (upd_rsp.valid & upd_rsp.sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_kind_q <= RK_NONE;
      rd_addr_q <= '0;
      k_q       <= '0;
      last_q    <= '0;
      steps_q   <= '0;
      pass_h_q  <= 1'b0;
      carry_q   <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      idx_ok_q  <= 1'b0;
      e_val_q   <= '0;
      h_val_q   <= '0;
      done_q    <= 1'b0;
      out_idx_q <= '0;
      e_out_q   <= '0;
      h_out_q   <= '0;
      ovf_out_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_kind_q <= rd_kind_d;
      rd_addr_q <= rd_addr_d;
      k_q       <= k_d;
      last_q    <= last_d;
      steps_q   <= steps_d;
      pass_h_q  <= pass_h_d;
      carry_q   <= carry_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      idx_ok_q  <= idx_ok_d;
      e_val_q   <= e_val_d;
      h_val_q   <= h_val_d;
      done_q    <= done_d;
      out_idx_q <= out_idx_d;
      e_out_q   <= e_out_d;
      h_out_q   <= h_out_d;
      ovf_out_q <= ovf_out_d;
    end
  end

  // write port: load beat or update write-back into the pass's target field
  assign e_we    = ((state_q == ST_LOAD) && idx_ok_q) || (upd_rsp.valid && !pass_h_q);
  assign h_we    = ((state_q == ST_LOAD) && idx_ok_q) || (upd_rsp.valid && pass_h_q);
  assign e_wdata = (state_q == ST_LOAD) ? e_val_q : upd_res;
  assign h_wdata = (state_q == ST_LOAD) ? h_val_q : upd_res;

  logic [AW-1:0] upd_tag_out;
  assign wr_addr = (state_q == ST_LOAD) ? AW'(idx_q) : upd_tag_out;

  fdtd1d_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (MAX_CELLS)
  ) u_e_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (wr_addr),
    .wdata_i (e_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (e_rdata)
  );

  fdtd1d_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (MAX_CELLS)
  ) u_h_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (wr_addr),
    .wdata_i (h_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (h_rdata)
  );

  fdtd1d_upd #(
    .AW (AW)
  ) u_upd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (upd_valid),
    .coeff_i (coeff_q),
    .old_i   (upd_old),
    .a_i     (upd_a),
    .b_i     (upd_b),
    .tag_i   (upd_tag),
    .rsp_o   (upd_rsp),
    .res_o   (upd_res),
    .tag_o   (upd_tag_out)
  );

  assign done_o           = done_q;
  assign cell_index_out_o = out_idx_q;
  assign e_out_o          = e_out_q;
  assign h_out_o          = h_out_q;
  assign overflow_o       = ovf_out_q;

  logic in_pass;
  assign in_pass = (state_q == ST_E_RUN) || (state_q == ST_E_DRAIN) ||
                   (state_q == ST_H_RUN) || (state_q == ST_H_DRAIN);

  `FDTD1D_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result beat while busy")
  `FDTD1D_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept left idle")
  `FDTD1D_ASSERT_IMP(a_wb_in_pass, clk_i, rst_ni, upd_rsp.valid, in_pass, "write-back outside a pass")
  `FDTD1D_ASSERT_NXT(a_ovf_sticky, clk_i, rst_ni, ovf_q, ovf_q, "overflow flag cleared")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fdtd_1d_periodic_step_core: drives load, read, step and
// unknown items, and checks every result beat against an in-bench Yee-ring predictor.
// Depends on fdtd1d_pkg (rtl/fdtd1d_pkg.sv) and rtl/fdtd_1d_periodic_step_core.sv.

module testbench;
  import fdtd1d_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNKNOWN = 2'd3;
  localparam longint             FIELD_MAX  = 64'sd2147483647;
  localparam longint             FIELD_MIN  = -64'sd2147483648;
  localparam logic [FIELD_W-1:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] NEG_LIMIT  = 32'h8000_0000;
  localparam int                 FILL_CELLS = 32;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] e;
    logic [FIELD_W-1:0] h;
    logic               ovf;
  } cell_beat_t;

  // Yee-ring predictor plus the queue of result beats still owed by the block.
  class field_scoreboard;
    logic [FIELD_W-1:0]    e_cells [MAX_CELLS_DEF];
    logic [FIELD_W-1:0]    h_cells [MAX_CELLS_DEF];
    logic                  ovf_seen = 1'b0;
    logic [CELL_CNT_W-1:0] ring_len = CELL_COUNT_RST;
    logic [COEF_W-1:0]     coeff    = COEF_RST;
    cell_beat_t            beat_q[$];
    int                    errors   = 0;

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == CFG_CELL_COUNT) ring_len = data[CELL_CNT_W-1:0];
      else coeff = data[COEF_W-1:0];
    endfunction

    // old + round(coeff * (a - b) / 2^16), ties away from zero, then clamp
    function logic [FIELD_W-1:0] advance_field(logic [FIELD_W-1:0] old,
                                               logic [FIELD_W-1:0] a,
                                               logic [FIELD_W-1:0] b);
      longint diff;
      longint mag;
      longint rnd;
      longint sum;
      logic   neg;
      diff = longint'($signed(a)) - longint'($signed(b));
      neg  = diff < 0;
      mag  = neg ? -diff : diff;
      rnd  = (mag * longint'(coeff) + 64'sd32768) >> FRAC_SHIFT;
      sum  = neg ? longint'($signed(old)) - rnd : longint'($signed(old)) + rnd;
      if (sum > FIELD_MAX) begin
        sum = FIELD_MAX;
        ovf_seen = 1'b1;
      end else if (sum < FIELD_MIN) begin
        sum = FIELD_MIN;
        ovf_seen = 1'b1;
      end
      return sum[FIELD_W-1:0];
    endfunction

    function void time_step();
      int n;
      int nb;
      n = (ring_len > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(ring_len);
      if (n == 0) return;
      for (int k = 0; k < n; k++) begin
        nb = (k == 0) ? n - 1 : k - 1;
        e_cells[k] = advance_field(e_cells[k], h_cells[nb], h_cells[k]);
      end
      for (int k = 0; k < n; k++) begin
        nb = (k == n - 1) ? 0 : k + 1;
        h_cells[k] = advance_field(h_cells[k], e_cells[k], e_cells[nb]);
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                            logic [FIELD_W-1:0] e_v, logic [FIELD_W-1:0] h_v,
                            logic [STEP_W-1:0] steps);
      cell_beat_t b;
      b = '0;
      case (op)
        OP_LOAD: begin
          e_cells[idx] = e_v;
          h_cells[idx] = h_v;
          b.idx = idx;
          b.e   = e_v;
          b.h   = h_v;
        end
        OP_STEP: begin
          for (int s = 0; s < int'(steps); s++) time_step();
        end
        OP_READ: begin
          b.idx = idx;
          b.e   = e_cells[idx];
          b.h   = h_cells[idx];
        end
        default: ;
      endcase
      b.ovf = ovf_seen;
      beat_q.push_back(b);
    endfunction

    function void compare_field(string what, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] e_v,
                               logic [FIELD_W-1:0] h_v, logic ovf);
      cell_beat_t want;
      if (beat_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none got index %0d",
                 $time, idx);
        return;
      end
      want = beat_q.pop_front();
      compare_field("cell_index_out", FIELD_W'(want.idx), FIELD_W'(idx));
      compare_field("e_out", want.e, e_v);
      compare_field("h_out", want.h, h_v);
      compare_field("overflow", FIELD_W'(want.ovf), FIELD_W'(ovf));
    endfunction

    function int pending();
      return beat_q.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i   = CFG_CELL_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i  = '0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         operation_i  = OP_LOAD;
  logic [IDX_W-1:0]        cell_index_i = '0;
  logic signed [FIELD_W-1:0] e_value_i  = '0;
  logic signed [FIELD_W-1:0] h_value_i  = '0;
  logic [STEP_W-1:0]       step_count_i = '0;
  logic                    done_o;
  logic [IDX_W-1:0]        cell_index_out_o;
  logic signed [FIELD_W-1:0] e_out_o;
  logic signed [FIELD_W-1:0] h_out_o;
  logic                    overflow_o;

  field_scoreboard sb = new();
  bit     idle_on       = 1'b1;
  int     n_items       = 0;
  int     n_reg_writes  = 0;
  longint n_time_steps  = 0;

  fdtd_1d_periodic_step_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .cell_index_i     (cell_index_i),
    .e_value_i        (e_value_i),
    .h_value_i        (h_value_i),
    .step_count_i     (step_count_i),
    .done_o           (done_o),
    .cell_index_out_o (cell_index_out_o),
    .e_out_o          (e_out_o),
    .h_out_o          (h_out_o),
    .overflow_o       (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Check a finishing beat before noting a new one accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(cell_index_out_o, e_out_o, h_out_o, overflow_o);
      if (start && busy === 1'b0)
        sb.note_item(operation_i, cell_index_i, e_value_i, h_value_i, step_count_i);
    end
  end

  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(0, 5))
      0:       return POS_LIMIT;
      1:       return NEG_LIMIT;
      2, 3:    return FIELD_W'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] rand_small();
    return FIELD_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] e_v, input logic [FIELD_W-1:0] h_v,
                           input logic [STEP_W-1:0] steps);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    cell_index_i <= idx;
    e_value_i    <= e_v;
    h_value_i    <= h_v;
    step_count_i <= steps;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    n_items++;
    if (op == OP_STEP) n_time_steps += steps;
  endtask

  // Drop start and wait until every owed beat has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(addr, data);
    n_reg_writes++;
    @(posedge clk_i);
  endtask

  initial begin
    int               ring;
    int               ring_eff;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [STEP_W-1:0] steps;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hold the ring to the filled cells so that no step or read touches an unwritten cell.
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'(FILL_CELLS));
    for (int k = 0; k < FILL_CELLS; k++)
      send_item(OP_LOAD, IDX_W'(k), rand_small(), rand_small(), STEP_W'($urandom));

    // Directed: full filled ring, then the corner cases.
    send_item(OP_STEP, IDX_W'($urandom), rand_field(), rand_field(), 16'd1);
    send_item(OP_READ, 10'd0, POS_LIMIT, NEG_LIMIT, 16'hFFFF);
    send_item(OP_STEP, 10'h3FF, NEG_LIMIT, POS_LIMIT, 16'd0);
    send_item(OP_UNKNOWN, 10'h3FF, POS_LIMIT, NEG_LIMIT, 16'hFFFF);
    send_item(OP_LOAD, 10'd0, POS_LIMIT, NEG_LIMIT, 16'd0);
    send_item(OP_LOAD, 10'h3FF, NEG_LIMIT, POS_LIMIT, 16'hFFFF);
    send_item(OP_STEP, 10'd0, '0, '0, 16'd1);
    send_item(OP_READ, 10'd0, '0, '0, 16'd0);
    send_item(OP_READ, 10'h3FF, '0, '0, 16'd0);

    settle();
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'(2));
    write_reg(CFG_COURANT, CFG_DATA_W'(65536));
    send_item(OP_LOAD, 10'd0, rand_small(), rand_small(), 16'd0);
    send_item(OP_LOAD, 10'd1, rand_small(), rand_small(), 16'd0);
    send_item(OP_STEP, 10'd0, '0, '0, 16'd3);
    send_item(OP_READ, 10'd1, '0, '0, 16'd0);
    send_item(OP_READ, 10'd2, '0, '0, 16'd0);

    settle();
    write_reg(CFG_COURANT, CFG_DATA_W'(0));
    send_item(OP_STEP, 10'd0, '0, '0, 16'd2);
    send_item(OP_READ, 10'd0, '0, '0, 16'd0);

    // Coefficient above 1.0 is used as given.
    settle();
    write_reg(CFG_COURANT, CFG_DATA_W'(131071));
    send_item(OP_STEP, 10'd0, '0, '0, 16'd2);
    send_item(OP_READ, 10'd1, '0, '0, 16'd0);

    // A single cell is its own neighbor; a zero ring leaves the fields unchanged.
    settle();
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'(1));
    send_item(OP_STEP, 10'd0, '0, '0, 16'h0FFF);
    send_item(OP_READ, 10'd0, '0, '0, 16'd0);
    settle();
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'(0));
    send_item(OP_STEP, 10'd0, '0, '0, 16'h8000);
    send_item(OP_READ, 10'd1, '0, '0, 16'd0);

    // Random phases, each under fresh register settings; the last two run without gaps.
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      idle_on = (ph < 8) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       ring = FILL_CELLS;
        1:       ring = $urandom_range(0, 1);
        default: ring = $urandom_range(2, 24);
      endcase
      ring_eff = (ring > MAX_CELLS_DEF) ? MAX_CELLS_DEF : ring;
      write_reg(CFG_CELL_COUNT, CFG_DATA_W'(ring));
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_COURANT, CFG_DATA_W'(0));
        1:       write_reg(CFG_COURANT, CFG_DATA_W'(65536));
        2:       write_reg(CFG_COURANT, CFG_DATA_W'($urandom_range(65537, 131071)));
        default: write_reg(CFG_COURANT, CFG_DATA_W'($urandom_range(0, 65536)));
      endcase
      for (int i = 0; i < 24; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_LOAD;
        else if (pick < 55) op = OP_STEP;
        else if (pick < 90) op = OP_READ;
        else                op = OP_UNKNOWN;
        // Mostly address cells on the ring, sometimes the parked cells beyond it.
        if (ring_eff > 0 && $urandom_range(0, 4) != 0)
          idx = IDX_W'($urandom_range(0, ring_eff - 1));
        else
          idx = IDX_W'($urandom_range(0, FILL_CELLS - 1));
        if (op != OP_STEP)  steps = STEP_W'($urandom);
        else if (ring > 64) steps = 16'd1;
        else                steps = STEP_W'($urandom_range(0, 6));
        send_item(op, idx, rand_field(), rand_field(), steps);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d items (%0d time steps in all) under %0d register writes,",
             n_items, n_time_steps, n_reg_writes);
    $display("covering loads, reads, steps, unknown opcodes, ring sizes 0 to %0d and saturation.",
             FILL_CELLS);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fdtd1d_pkg.sv
rtl/fdtd1d_ram.sv
rtl/fdtd1d_upd.sv
rtl/fdtd_1d_periodic_step_core.sv
tb/testbench.sv
